### design/aptt_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive priority timeout tuner package
// Shared widths, thresholds, reset values and the divider result type.
// ----------------------------------------------------------------------------
package aptt_pkg;

  localparam int LEVELS = 4;
  localparam int LVL_W  = 2;
  localparam int TMO_W  = 16;
  localparam int LIM_W  = 16;
  localparam int UTIL_W = 8;
  localparam int TOT_W  = 10;
  // Width of queue_depth * 100 for a 16-bit depth.
  localparam int DIVD_W = 23;

  localparam logic [UTIL_W-1:0] HIGH_THR  = 8'd80;
  localparam logic [UTIL_W-1:0] CRIT_THR  = 8'd95;
  localparam logic [UTIL_W-1:0] PERCENT   = 8'd100;
  localparam logic [UTIL_W-1:0] UTIL_SAT  = 8'd255;
  localparam logic [TMO_W-1:0]  MIN_TMO   = 16'd5;
  localparam logic [TMO_W-1:0]  TMO_STEP  = 16'd10;
  localparam logic [TMO_W-1:0]  TMO_SAT   = 16'hFFFF;

  localparam logic OP_ADJUST  = 1'b0;
  localparam logic OP_RESTORE = 1'b1;

  // Bit 2 of the register index selects the register bank.
  localparam logic REG_BANK_LIMIT   = 1'b0;
  localparam logic REG_BANK_DEFAULT = 1'b1;

  localparam logic [LVL_W-1:0] LVL_EMERGENCY = 2'd0;
  localparam logic [LVL_W-1:0] LVL_INFO      = 2'd3;

  localparam logic [LEVELS-1:0][LIM_W-1:0] RST_LIMIT =
    {16'd100, 16'd50, 16'd20, 16'd10};
  localparam logic [LEVELS-1:0][TMO_W-1:0] RST_TMO =
    {16'd500, 16'd100, 16'd50, 16'd10};

  typedef struct packed {
    logic              done;
    logic [UTIL_W-1:0] quot;
  } div_res_t;

endpackage

### design/adaptive_priority_timeout_tuner.sv
// ----------------------------------------------------------------------------
// Adaptive priority timeout tuner
// Per-level timeout and utilization keeping for four priority levels.
// ----------------------------------------------------------------------------
// The block handles one item at a time and drops in_ready from the edge that
// accepts an item until its result has been loaded into the output register.
// A restore item passes through the update and output states. An adjust item
// first passes the multiply state; on a level whose depth limit is 0 it reads
// as full load there and skips the divider. An adjust item whose utilization
// would pass 255 stops the divider after its saturation check. For any other
// adjust item the multiply state forms queue_depth * 100, then the shared
// divider runs its saturation check and produces the quotient one bit at a
// time, followed by a handoff, an update and an output state. The output
// state waits for as long as an earlier result still sits in the output
// register. That register lets a finished result wait for out_ready while the
// next item is already accepted and worked on. Configuration writes take
// effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module adaptive_priority_timeout_tuner (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_wdata,
  // Input item channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [aptt_pkg::LVL_W-1:0]   in_level,
  input  logic [15:0]                  in_queue_depth,
  // Result item channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [aptt_pkg::UTIL_W-1:0]  out_utilization,
  output logic [aptt_pkg::TMO_W-1:0]   out_timeout,
  output logic [aptt_pkg::TOT_W-1:0]   out_total_utilization,
  output logic [aptt_pkg::UTIL_W-1:0]  out_average_utilization
);
  import aptt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_UPD, S_OUT} state_t;

  state_t                        state_r;

  // Configuration registers: depth limits and restore timeouts per level.
  logic [LEVELS-1:0][LIM_W-1:0]  limit_r;
  logic [LEVELS-1:0][TMO_W-1:0]  dflt_r;

  // Per-level state.
  logic [LEVELS-1:0][TMO_W-1:0]  tmo_r;
  logic [LEVELS-1:0][UTIL_W-1:0] utl_r;

  // The item being worked on.
  logic                          op_r;
  logic [LVL_W-1:0]              lvl_r;
  logic [15:0]                   depth_r;
  logic [UTIL_W-1:0]             util_r;
  logic                          status_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_status_r;
  logic [UTIL_W-1:0]             out_util_r;
  logic [TMO_W-1:0]              out_tmo_r;
  logic [TOT_W-1:0]              out_total_r;

  logic                          div_start;
  logic [DIVD_W-1:0]             product;
  div_res_t                      div_res;

  logic [TMO_W-1:0]              cur_tmo;
  logic [TMO_W-1:0]              half_tmo;
  logic [TMO_W:0]                inc_tmo;
  logic [TMO_W-1:0]              new_tmo;
  logic                          new_status;
  logic [TOT_W-1:0]              total;
  logic                          in_acc;
  logic                          out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Multiplying by 100 is a constant multiply; the divider registers it.
  assign product   = DIVD_W'(depth_r) * DIVD_W'(PERCENT);
  assign div_start = (state_r == S_MUL) && (limit_r[lvl_r] != '0);

  aptt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (limit_r[lvl_r]),
    .res      (div_res)
  );

  // Timeout tuning from the fresh utilization. Critical load halves the
  // timeout with a floor on every level but emergency; high load adds a
  // fixed step with saturation on every level but info, and always reports.
  always_comb begin
    cur_tmo    = tmo_r[lvl_r];
    half_tmo   = cur_tmo >> 1;
    inc_tmo    = {1'b0, cur_tmo} + {1'b0, TMO_STEP};
    new_tmo    = cur_tmo;
    new_status = 1'b0;
    if (util_r >= CRIT_THR) begin
      if (lvl_r != LVL_EMERGENCY) begin
        new_tmo    = (half_tmo < MIN_TMO) ? MIN_TMO : half_tmo;
        new_status = 1'b1;
      end
    end else if (util_r >= HIGH_THR) begin
      if (lvl_r != LVL_INFO) begin
        new_tmo = inc_tmo[TMO_W] ? TMO_SAT : inc_tmo[TMO_W-1:0];
      end
      new_status = 1'b1;
    end
  end

  // Sum of the stored utilizations, taken after the update has landed.
  always_comb begin
    total = '0;
    for (int i = 0; i < LEVELS; i++) begin
      total = total + TOT_W'(utl_r[i]);
    end
  end

  // Configuration writes go straight into the register banks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= RST_LIMIT;
      dflt_r  <= RST_TMO;
    end else if (cfg_we) begin
      if (cfg_index[2] == REG_BANK_LIMIT) begin
        limit_r[cfg_index[1:0]] <= cfg_wdata;
      end else begin
        dflt_r[cfg_index[1:0]] <= cfg_wdata;
      end
    end
  end

  // Sequencer: accept, form the utilization of an adjust item, update the
  // level, then hand the result to the output register once it is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tmo_r       <= RST_TMO;
      utl_r       <= '0;
    end else begin
      // A new result replaces one that leaves in the same cycle.
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_op;
            lvl_r   <= in_level;
            depth_r <= in_queue_depth;
            state_r <= (in_op == OP_RESTORE) ? S_UPD : S_MUL;
          end
        end
        S_MUL: begin
          // A zero limit reads as full load without a division.
          if (limit_r[lvl_r] == '0) begin
            util_r  <= PERCENT;
            state_r <= S_UPD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            util_r  <= div_res.quot;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (op_r == OP_RESTORE) begin
            tmo_r[lvl_r] <= dflt_r[lvl_r];
            utl_r[lvl_r] <= '0;
            status_r     <= 1'b0;
          end else begin
            tmo_r[lvl_r] <= new_tmo;
            utl_r[lvl_r] <= util_r;
            status_r     <= new_status;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_util_r   <= utl_r[lvl_r];
            out_tmo_r    <= tmo_r[lvl_r];
            out_total_r  <= total;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_utilization         = out_util_r;
  assign out_timeout             = out_tmo_r;
  assign out_total_utilization   = out_total_r;
  assign out_average_utilization = out_total_r[TOT_W-1:2];

`ifndef SYNTHESIS
  // In the cycle after an item is taken, the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside of the division wait");

  // A level's utilization is part of the reported total.
  a_total_covers_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_total_r >= TOT_W'(out_util_r)))
    else $error("total utilization below the level's utilization");
`endif

endmodule

### design/aptt_div.sv
// ----------------------------------------------------------------------------
// Saturating radix-2 divider
// Restoring division of a 23-bit dividend by a nonzero 16-bit divisor,
// giving an 8-bit quotient that saturates at 255, one bit per cycle.
// ----------------------------------------------------------------------------
module aptt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [aptt_pkg::DIVD_W-1:0]  dividend,
  input  logic [aptt_pkg::LIM_W-1:0]   divisor,
  output aptt_pkg::div_res_t           res
);
  import aptt_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

  dstate_t             state_r;
  logic [DIVD_W-1:0]   dvd_r;
  logic [LIM_W-1:0]    dsr_r;
  logic [LIM_W-1:0]    rem_r;
  logic [UTIL_W-1:0]   quot_r;
  logic [2:0]          cnt_r;
  logic                done_r;

  // The single subtractor serves both the range check and every step.
  logic [LIM_W:0]      opnd;
  logic [LIM_W+1:0]    diff;
  logic                ge;

  always_comb begin
    if (state_r == D_CHECK) begin
      opnd = {2'b00, dvd_r[DIVD_W-1:UTIL_W]};
    end else begin
      opnd = {rem_r, dvd_r[UTIL_W-1]};
    end
    diff = {1'b0, opnd} - {2'b00, dsr_r};
    ge   = ~diff[LIM_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            dvd_r   <= dividend;
            dsr_r   <= divisor;
            state_r <= D_CHECK;
          end
        end
        D_CHECK: begin
          // A high part not below the divisor means a quotient of 256 or more.
          if (ge) begin
            quot_r  <= UTIL_SAT;
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            rem_r   <= opnd[LIM_W-1:0];
            quot_r  <= '0;
            cnt_r   <= 3'd7;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r  <= ge ? diff[LIM_W-1:0] : opnd[LIM_W-1:0];
          quot_r <= {quot_r[UTIL_W-2:0], ge};
          dvd_r  <= {dvd_r[DIVD_W-2:0], 1'b0};
          cnt_r  <= cnt_r - 3'd1;
          if (cnt_r == 3'd0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

### bench/adaptive_priority_timeout_tuner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adaptive priority timeout tuner testbench
// Drives adjust and restore items through randomly paced handshakes. A
// behavioral copy of the per-level timeouts and utilizations predicts every
// result but those of pinned rows, and each result is compared field by field.
// ----------------------------------------------------------------------------
module adaptive_priority_timeout_tuner_tb;
  import aptt_pkg::*;

  // The package names only the outer two levels.
  localparam logic [LVL_W-1:0] LVL_ERROR   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_WARNING = 2'd2;

  localparam int MAX_GAP         = 19;
  // Long enough for the output register and the work stage to fill up, so
  // that in_ready stays low while the sender keeps offering.
  localparam int HOLD_CYCLES     = 200;
  // Cycles in which neither channel moves before the run is declared hung. The
  // slowest legal stretch is the hold above plus one item's gaps and latency.
  localparam int IDLE_LIMIT      = 1000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 100;
  // Longer than the slowest item takes, so this covers any stray late result.
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_PRINTED     = 100;

  // One result item, in the order of the output ports.
  typedef struct packed {
    logic              status;
    logic [UTIL_W-1:0] utilization;
    logic [TMO_W-1:0]  timeout;
    logic [TOT_W-1:0]  total;
    logic [UTIL_W-1:0] average;
  } tuning_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One row of the directed table. An item row uses op, level and data as
  // the queue depth; a register row writes data to register {bank, level}.
  // A pinned row carries its expected result typed in by hand.
  typedef struct packed {
    row_kind_t         kind;
    logic              op;
    logic [LVL_W-1:0]  level;
    logic              bank;
    logic [15:0]       data;
    logic              pinned;
    tuning_t           want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_ADJUST;
  logic [LVL_W-1:0]    in_level = '0;
  logic [15:0]         in_queue_depth = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_status;
  logic [UTIL_W-1:0]   out_utilization;
  logic [TMO_W-1:0]    out_timeout;
  logic [TOT_W-1:0]    out_total_utilization;
  logic [UTIL_W-1:0]   out_average_utilization;

  // Shadow copy of the block's registers and per-level state.
  logic [LIM_W-1:0]    depth_limit [LEVELS];
  logic [TMO_W-1:0]    default_tmo [LEVELS];
  logic [TMO_W-1:0]    level_tmo   [LEVELS];
  logic [UTIL_W-1:0]   level_util  [LEVELS];

  // Results expected for accepted items, oldest first.
  tuning_t             expected_tunings [$];
  tuning_t             oldest;
  int unsigned         mismatches = 0;
  int unsigned         idle_cycles = 0;
  // Pacing controls: no_idle for the sender and the receiver, hold_pending for the receiver.
  bit                  no_idle = 1'b0;
  bit                  hold_pending = 1'b0;

  adaptive_priority_timeout_tuner uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_op                   (in_op),
    .in_level                (in_level),
    .in_queue_depth          (in_queue_depth),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_status              (out_status),
    .out_utilization         (out_utilization),
    .out_timeout             (out_timeout),
    .out_total_utilization   (out_total_utilization),
    .out_average_utilization (out_average_utilization)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one item to the shadow state and returns the result it causes.
  function automatic tuning_t tune_level(input logic op, input logic [LVL_W-1:0] lv,
                                         input logic [15:0] depth);
    tuning_t          r;
    logic [31:0]      pct;
    logic [TMO_W-1:0] halved;
    logic [TMO_W:0]   bumped;
    logic [TOT_W-1:0] sum;
    r = '0;
    if (op == OP_RESTORE) begin
      // Restore reloads the default even when it is zero.
      level_tmo[lv] = default_tmo[lv];
      level_util[lv] = '0;
    end else begin
      // A zero depth limit reads as full load; anything above 255 percent
      // saturates instead of wrapping.
      if (depth_limit[lv] == '0) begin
        pct = 32'(PERCENT);
      end else begin
        pct = (32'(depth) * 32'd100) / 32'(depth_limit[lv]);
      end
      if (pct > 32'(UTIL_SAT)) begin
        pct = 32'(UTIL_SAT);
      end
      level_util[lv] = pct[UTIL_W-1:0];
      if (pct >= 32'(CRIT_THR)) begin
        // Critical load: the emergency level is left alone and reports no
        // change, every other level halves its timeout down to the floor.
        if (lv != LVL_EMERGENCY) begin
          halved = level_tmo[lv] >> 1;
          level_tmo[lv] = (halved < MIN_TMO) ? MIN_TMO : halved;
          r.status = 1'b1;
        end
      end else if (pct >= 32'(HIGH_THR)) begin
        // High load: the info level keeps its timeout but still reports.
        if (lv != LVL_INFO) begin
          bumped = {1'b0, level_tmo[lv]} + {1'b0, TMO_STEP};
          level_tmo[lv] = bumped[TMO_W] ? TMO_SAT : bumped[TMO_W-1:0];
        end
        r.status = 1'b1;
      end
    end
    sum = '0;
    for (int i = 0; i < LEVELS; i++) begin
      sum = sum + TOT_W'(level_util[i]);
    end
    r.utilization = level_util[lv];
    r.timeout = level_tmo[lv];
    r.total = sum;
    r.average = UTIL_W'(sum >> 2);
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic op, input logic [LVL_W-1:0] lv,
                                         input logic [15:0] depth);
    return '{ROW_ITEM, op, lv, REG_BANK_LIMIT, depth, 1'b0, '0};
  endfunction

  function automatic plan_row_t pinned_row(input logic op, input logic [LVL_W-1:0] lv,
                                           input logic [15:0] depth, input tuning_t r);
    return '{ROW_ITEM, op, lv, REG_BANK_LIMIT, depth, 1'b1, r};
  endfunction

  function automatic plan_row_t cfg_row(input logic bank, input logic [LVL_W-1:0] lv,
                                        input logic [15:0] value);
    return '{ROW_CFG, OP_ADJUST, lv, bank, value, 1'b0, '0};
  endfunction

  // Depth limit for a random phase: the first two phases pin the extremes,
  // the rest mix zero, the maximum and mostly small limits.
  function automatic logic [15:0] pick_limit(input int phase);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (phase == 0) begin
      return 16'hFFFF;
    end else if (phase == 1) begin
      return 16'd1;
    end else if (roll < 15) begin
      return 16'd0;
    end else if (roll < 25) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(300, 1));
  endfunction

  // Default timeout for a random phase: small values reach the floor fast,
  // values near the top reach saturation.
  function automatic logic [15:0] pick_default(input int phase);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (phase == 0) begin
      return 16'hFFFF;
    end else if (phase == 1) begin
      return 16'd1;
    end else if (roll < 20) begin
      return 16'($urandom_range(20, 1));
    end else if (roll < 40) begin
      return 16'($urandom_range(65535, 65500));
    end
    return 16'($urandom_range(65535, 1));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  // Offers one item after a random gap and records its expected result once
  // the block takes it. Valid is left high so that a back-to-back item follows
  // without a dip.
  task automatic submit_request(input logic op, input logic [LVL_W-1:0] lv,
                                input logic [15:0] depth, input bit pinned,
                                input tuning_t pinned_result);
    int unsigned gap;
    tuning_t     predicted;
    gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_level <= lv;
    in_queue_depth <= depth;
    do @(posedge clk); while (!in_ready);
    // The shadow state always advances, even when the row is pinned.
    predicted = tune_level(op, lv, depth);
    expected_tunings.push_back(pinned ? pinned_result : predicted);
  endtask

  // Stops offering and waits until every outstanding result is back. Every
  // item causes a result, so an empty store means the block is idle.
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tunings.size() != 0) @(posedge clk);
  endtask

  // Writes register {bank, level} with a one-cycle enable pulse.
  task automatic program_register(input logic bank, input logic [LVL_W-1:0] lv,
                                  input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= {bank, lv};
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (bank == REG_BANK_LIMIT) begin
      depth_limit[lv] = value;
    end else begin
      default_tmo[lv] = value;
    end
  endtask

  // Result receiver: stalls a random number of cycles before each result,
  // or for one long stretch when a hold is requested.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_tunings.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        oldest = expected_tunings.pop_front();
        if (out_status !== oldest.status)
          report_mismatch("status", oldest.status, out_status);
        if (out_utilization !== oldest.utilization)
          report_mismatch("utilization", oldest.utilization, out_utilization);
        if (out_timeout !== oldest.timeout)
          report_mismatch("timeout", oldest.timeout, out_timeout);
        if (out_total_utilization !== oldest.total)
          report_mismatch("total utilization", oldest.total, out_total_utilization);
        if (out_average_utilization !== oldest.average)
          report_mismatch("average utilization", oldest.average, out_average_utilization);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("adaptive_priority_timeout_tuner_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t        directed_plan [25];
    logic             op;
    logic [LVL_W-1:0] lv;
    logic [15:0]      depth;
    int unsigned      roll;
    int unsigned      pct;
    int unsigned      scaled;

    for (int i = 0; i < LEVELS; i++) begin
      depth_limit[i] = RST_LIMIT[i];
      default_tmo[i] = RST_TMO[i];
      level_tmo[i] = RST_TMO[i];
      level_util[i] = '0;
    end

    // Directed part, starting from the reset limits 10, 20, 50, 100 and
    // timeouts 10, 50, 100, 500.
    directed_plan = '{
      // Restore ignores the depth; the emergency level is at its defaults.
      pinned_row(OP_RESTORE, LVL_EMERGENCY, 16'hFFFF, tuning_t'{1'b0, 8'd0, 16'd10, 10'd0, 8'd0}),
      pinned_row(OP_ADJUST, LVL_EMERGENCY, 16'd0, tuning_t'{1'b0, 8'd0, 16'd10, 10'd0, 8'd0}),
      // Largest depth saturates at 255; the emergency level ignores critical load.
      pinned_row(OP_ADJUST, LVL_EMERGENCY, 16'hFFFF,
                 tuning_t'{1'b0, 8'd255, 16'd10, 10'd255, 8'd63}),
      // Exactly 80 percent on the emergency level adds 10.
      pinned_row(OP_ADJUST, LVL_EMERGENCY, 16'd8, tuning_t'{1'b1, 8'd80, 16'd20, 10'd80, 8'd20}),
      // Both sides of the critical and the high thresholds.
      item_row(OP_ADJUST, LVL_ERROR, 16'd19),
      item_row(OP_ADJUST, LVL_ERROR, 16'd18),
      item_row(OP_ADJUST, LVL_WARNING, 16'd40),
      item_row(OP_ADJUST, LVL_WARNING, 16'd39),
      // The info level reports high load without changing its timeout, then halves it at critical load.
      item_row(OP_ADJUST, LVL_INFO, 16'd85),
      item_row(OP_ADJUST, LVL_INFO, 16'd94),
      item_row(OP_ADJUST, LVL_INFO, 16'd95),
      // A zero default and a zero depth limit.
      cfg_row(REG_BANK_DEFAULT, LVL_INFO, 16'd0),
      cfg_row(REG_BANK_LIMIT, LVL_ERROR, 16'd0),
      item_row(OP_RESTORE, LVL_INFO, 16'd1234),
      // Halving a zero timeout lands on the floor.
      item_row(OP_ADJUST, LVL_INFO, 16'hFFFF),
      // With a zero limit any depth reads as 100 percent.
      item_row(OP_ADJUST, LVL_ERROR, 16'd0),
      item_row(OP_ADJUST, LVL_ERROR, 16'hFFFF),
      // The largest timeout saturates under high load.
      cfg_row(REG_BANK_DEFAULT, LVL_WARNING, 16'hFFFF),
      cfg_row(REG_BANK_LIMIT, LVL_WARNING, 16'hFFFF),
      item_row(OP_RESTORE, LVL_WARNING, 16'd0),
      item_row(OP_ADJUST, LVL_WARNING, 16'd52428),
      item_row(OP_ADJUST, LVL_WARNING, 16'hFFFF),
      // Smallest nonzero limit.
      cfg_row(REG_BANK_LIMIT, LVL_EMERGENCY, 16'd1),
      item_row(OP_ADJUST, LVL_EMERGENCY, 16'd1),
      item_row(OP_ADJUST, LVL_EMERGENCY, 16'd3)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        await_idle();
        program_register(directed_plan[r].bank, directed_plan[r].level,
                         directed_plan[r].data);
      end else begin
        submit_request(directed_plan[r].op, directed_plan[r].level, directed_plan[r].data,
                       directed_plan[r].pinned, directed_plan[r].want);
      end
    end

    // Random phases. Each one reprograms all eight registers while the block
    // is idle. One phase runs with no gaps at all on either side, and one
    // starts with a long receiver stall so the block backs up into in_ready.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      await_idle();
      for (int i = 0; i < LEVELS; i++) begin
        program_register(REG_BANK_LIMIT, LVL_W'(i), pick_limit(phase));
        program_register(REG_BANK_DEFAULT, LVL_W'(i), pick_default(phase));
      end
      no_idle = (phase == 2);
      hold_pending = (phase == 3);
      repeat (ITEMS_PER_PHASE) begin
        lv = LVL_W'($urandom_range(LEVELS - 1, 0));
        op = ($urandom_range(99, 0) < 15) ? OP_RESTORE : OP_ADJUST;
        roll = $urandom_range(99, 0);
        if (roll < 20 || depth_limit[lv] == '0) begin
          // Full-range depth, so every bit of the field toggles.
          depth = 16'($urandom);
        end else begin
          // Depth scaled to the level's limit, mostly near the thresholds.
          pct = (roll < 60) ? $urandom_range(97, 76) : $urandom_range(130, 0);
          scaled = depth_limit[lv] * pct / 100;
          depth = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
        end
        submit_request(op, lv, depth, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    await_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("adaptive_priority_timeout_tuner_tb passed");
    end else begin
      $display("adaptive_priority_timeout_tuner_tb failed");
    end
    $finish;
  end

endmodule
